### rtl/core/ehd_pkg.sv
`timescale 1ns / 1ps

package ehd_pkg;

  localparam int EntityWindow = 12;
  localparam int NumCells     = EntityWindow + 1;
  localparam int IdxW         = $clog2(NumCells);
  localparam int CntW         = $clog2(NumCells + 1);
  localparam int CpW          = 21;

  localparam logic [CpW-1:0] CpMax = 21'h10FFFF;

  localparam logic [7:0] CharAmp  = 8'h26;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharLt   = 8'h3C;
  localparam logic [7:0] CharGt   = 8'h3E;
  localparam logic [7:0] CharQuot = 8'h22;
  localparam logic [7:0] CharApos = 8'h27;
  localparam logic [7:0] CharLowX = 8'h78;
  localparam logic [7:0] CharUpX  = 8'h58;

  localparam logic [23:0] NameAmp  = "amp";
  localparam logic [15:0] NameLt   = "lt";
  localparam logic [15:0] NameGt   = "gt";
  localparam logic [31:0] NameQuot = "quot";
  localparam logic [31:0] NameApos = "apos";

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_DEC,
    ST_VERB
  } scan_state_e;

  typedef struct packed {
    logic            shift;
    logic            load;
    logic [IdxW-1:0] load_idx;
  } chain_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

endpackage

### rtl/core/ehd_cell.sv
`timescale 1ns / 1ps

module ehd_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic       load_i,
  input  logic [7:0] right_i,
  input  logic [7:0] in_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = in_i;
    end else if (shift_i) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/core/ehd_scan.sv
`timescale 1ns / 1ps

module ehd_scan import ehd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic                      in_valid_i,
  input  logic                      in_last_i,
  input  logic [NumCells-1:0][7:0]  cells_i,
  output logic                      ready_o,
  output chain_ctl_t                ctl_o,
  output emit_t                     emit_o
);

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf_t;

  function automatic utf_t utf8_enc(input logic [CpW-1:0] cp);
    utf_t u;
    u = '0;
    if (cp < CpW'(21'h80)) begin
      u.len  = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp < CpW'(21'h800)) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < CpW'(21'h10000)) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  scan_state_e     state_q, state_d;
  logic [CntW-1:0] n_q, n_d;
  logic [IdxW-1:0] p_q, p_d;
  logic            str_last_q, str_last_d;
  logic [CntW-1:0] dcnt_q, dcnt_d;
  logic [2:0]      ucnt_q, ucnt_d;
  logic            ulast_q, ulast_d;
  logic [3:0][7:0] ub_q, ub_d;
  logic            hash_q, hash_d;
  logic            hex_q, hex_d;
  logic            num_ok_q, num_ok_d;
  logic            big_q, big_d;
  logic [CpW-1:0]  cp_q, cp_d;

  logic [7:0]      b;
  logic [IdxW-1:0] len;
  logic            in_scan, have_byte, tail_fail, in_win, win_full, is_semi;
  logic            act_pass, act_open, act_add, act_semi, act_dec, act_verb, act_fail;
  logic            name_hit, num_hit;
  logic [CpW-1:0]  name_cp, cp_sel;
  utf_t            utf;
  logic            is_dec, hex_ok, digit_ok;
  logic [3:0]      hex_v, dig;
  logic [CpW+3:0]  mul, nxt;
  logic            nxt_big;

  assign b        = cells_i[p_q];
  assign len      = p_q - IdxW'(1);
  assign in_scan  = (state_q == ST_SCAN) && go_i;
  assign have_byte = CntW'(p_q) < n_q;
  assign tail_fail = !have_byte && (n_q != '0) && str_last_q;
  assign win_full = p_q >= IdxW'(EntityWindow);
  assign is_semi  = b == CharSemi;
  assign in_win   = in_scan && have_byte && (p_q != '0);

  always_comb begin
    name_hit = 1'b1;
    name_cp  = '0;
    if (len == IdxW'(3) && {cells_i[1], cells_i[2], cells_i[3]} == NameAmp) begin
      name_cp = CpW'(CharAmp);
    end else if (len == IdxW'(2) && {cells_i[1], cells_i[2]} == NameLt) begin
      name_cp = CpW'(CharLt);
    end else if (len == IdxW'(2) && {cells_i[1], cells_i[2]} == NameGt) begin
      name_cp = CpW'(CharGt);
    end else if (len == IdxW'(4) &&
                 {cells_i[1], cells_i[2], cells_i[3], cells_i[4]} == NameQuot) begin
      name_cp = CpW'(CharQuot);
    end else if (len == IdxW'(4) &&
                 {cells_i[1], cells_i[2], cells_i[3], cells_i[4]} == NameApos) begin
      name_cp = CpW'(CharApos);
    end else begin
      name_hit = 1'b0;
    end
  end

  assign num_hit = hash_q && num_ok_q && (hex_q ? (len > IdxW'(2)) : (len > IdxW'(1)));
  assign cp_sel  = name_hit ? name_cp : cp_q;
  assign utf     = utf8_enc(cp_sel);

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_v = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      hex_v = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_dec   = (b >= 8'h30) && (b <= 8'h39);
  assign digit_ok = hex_q ? hex_ok : is_dec;
  assign dig      = hex_q ? hex_v : b[3:0];
  assign mul      = hex_q ? {cp_q, 4'b0000}
                          : ({1'b0, cp_q, 3'b000} + {3'b000, cp_q, 1'b0});
  assign nxt      = mul + (CpW+4)'(dig);
  assign nxt_big  = nxt > (CpW+4)'(CpMax);

  assign act_pass = in_scan && have_byte && (p_q == '0) && (b != CharAmp);
  assign act_open = in_scan && have_byte && (p_q == '0) && (b == CharAmp);
  assign act_semi = in_win && is_semi;
  assign act_dec  = act_semi && (name_hit || (num_hit && !big_q));
  assign act_verb = act_semi && !name_hit && num_hit && big_q;
  assign act_add  = in_win && !is_semi && !win_full;
  assign act_fail = (act_semi && !name_hit && !num_hit) ||
                    (in_win && !is_semi && win_full) ||
                    (in_scan && tail_fail);

  assign ready_o = in_scan &&
                   ((!have_byte && !tail_fail) ||
                    ((act_pass || act_open || act_add) &&
                     (CntW'(p_q) + CntW'(1) == n_q) && !str_last_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SCAN: begin
        if (act_dec) begin
          state_d = ST_DEC;
        end else if (act_verb) begin
          state_d = ST_VERB;
        end
      end
      ST_VERB: begin
        if (go_i && dcnt_q == CntW'(1)) begin
          state_d = ST_SCAN;
        end
      end
      ST_DEC: begin
        if (go_i && ucnt_q <= 3'd1 && dcnt_q <= CntW'(1)) begin
          state_d = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_SCAN;
      end
    endcase
  end

  always_comb begin
    n_d        = n_q;
    p_d        = p_q;
    str_last_d = str_last_q;
    dcnt_d     = dcnt_q;
    ucnt_d     = ucnt_q;
    ulast_d    = ulast_q;
    ub_d       = ub_q;
    hash_d     = hash_q;
    hex_d      = hex_q;
    num_ok_d   = num_ok_q;
    big_d      = big_q;
    cp_d       = cp_q;
    ctl_o      = '0;
    emit_o     = '0;

    case (state_q)
      ST_SCAN: begin
        if (act_pass) begin
          emit_o.valid = 1'b1;
          emit_o.data  = b;
          emit_o.last  = str_last_q && (n_q == CntW'(1));
          ctl_o.shift  = 1'b1;
        end else if (act_open) begin
          p_d = IdxW'(1);
        end else if (act_add) begin
          p_d = p_q + IdxW'(1);
          if (p_q == IdxW'(1)) begin
            hash_d   = b == CharHash;
            hex_d    = 1'b0;
            num_ok_d = 1'b1;
            big_d    = 1'b0;
            cp_d     = '0;
          end else if (p_q == IdxW'(2) && (b == CharLowX || b == CharUpX)) begin
            hex_d = 1'b1;
          end else if (digit_ok) begin
            if (!big_q) begin
              if (nxt_big) begin
                big_d = 1'b1;
              end else begin
                cp_d = nxt[CpW-1:0];
              end
            end
          end else begin
            num_ok_d = 1'b0;
          end
        end else if (act_fail) begin
          emit_o.valid = 1'b1;
          emit_o.data  = CharAmp;
          emit_o.last  = str_last_q && (n_q == CntW'(1));
          ctl_o.shift  = 1'b1;
          p_d          = '0;
        end else if (act_dec) begin
          p_d     = '0;
          ub_d    = utf.b;
          ucnt_d  = utf.len;
          dcnt_d  = CntW'(p_q) + CntW'(1);
          ulast_d = str_last_q && (n_q == CntW'(p_q) + CntW'(1));
        end else if (act_verb) begin
          p_d    = '0;
          dcnt_d = CntW'(p_q) + CntW'(1);
        end
      end
      ST_VERB: begin
        if (go_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = cells_i[0];
          emit_o.last  = str_last_q && (n_q == CntW'(1));
          ctl_o.shift  = 1'b1;
          dcnt_d       = dcnt_q - CntW'(1);
        end
      end
      ST_DEC: begin
        if (go_i) begin
          if (ucnt_q != 3'd0) begin
            emit_o.valid = 1'b1;
            emit_o.data  = ub_q[0];
            emit_o.last  = ulast_q && (ucnt_q == 3'd1);
            ub_d         = {8'h00, ub_q[3:1]};
            ucnt_d       = ucnt_q - 3'd1;
          end
          if (dcnt_q != '0) begin
            ctl_o.shift = 1'b1;
            dcnt_d      = dcnt_q - CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    ctl_o.load     = in_valid_i && ready_o;
    ctl_o.load_idx = IdxW'(n_q - CntW'(ctl_o.shift));
    n_d            = n_q - CntW'(ctl_o.shift) + CntW'(ctl_o.load);
    if (ctl_o.load) begin
      str_last_d = in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SCAN;
      n_q        <= '0;
      p_q        <= '0;
      str_last_q <= 1'b0;
      dcnt_q     <= '0;
      ucnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      p_q        <= p_d;
      str_last_q <= str_last_d;
      dcnt_q     <= dcnt_d;
      ucnt_q     <= ucnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ulast_q  <= ulast_d;
    ub_q     <= ub_d;
    hash_q   <= hash_d;
    hex_q    <= hex_d;
    num_ok_q <= num_ok_d;
    big_q    <= big_d;
    cp_q     <= cp_d;
  end

endmodule

### rtl/core/html_entity_decoder.sv
`timescale 1ns / 1ps

// Byte-stream HTML entity decoder. Plain text moves at one byte per cycle while
// the output can advance: a row of 13 byte cells holds the open '&' window, and
// a scanner walks it one byte per cycle while the output can advance. On ';' a
// named or numeric entity is sent as 1 to 4 UTF-8 bytes while the window cells
// drain; a number at or above 0x110000 sends the window verbatim, one byte per
// cycle while the output can advance. An unknown or overlong window sends '&'
// and rescans the buffered bytes one per cycle while the output can advance.
// With in_last_i set, any open window is flushed and the final byte of the
// string carries out_last_o. Input is held off (in_stall_o) during decode,
// verbatim copy, rescan and end-of-string flush, and whenever the output
// register cannot advance.
module html_entity_decoder import ehd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic                     go;
  logic                     ready;
  chain_ctl_t               ctl;
  emit_t                    emit;
  logic [NumCells-1:0][7:0] cells;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  assign go = !out_valid_q || !out_stall_i;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [7:0] right;
    logic       load_en;

    if (i == NumCells - 1) begin : g_end
      assign right = 8'h00;
    end else begin : g_mid
      assign right = cells[i+1];
    end

    assign load_en = ctl.load && (ctl.load_idx == IdxW'(i));

    ehd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl.shift),
      .load_i  (load_en),
      .right_i (right),
      .in_i    (in_byte_i),
      .data_o  (cells[i])
    );
  end

  ehd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .cells_i    (cells),
    .ready_o    (ready),
    .ctl_o      (ctl),
    .emit_o     (emit)
  );

  assign in_stall_o = !ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = emit.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit.valid) begin
      out_byte_q <= emit.data;
      out_last_q <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTH
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> go)
    else $error("byte produced while the output register is blocked");

  a_load_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |-> (ctl.load_idx < IdxW'(NumCells)) && go)
    else $error("cell load outside the chain or while output is blocked");

  a_last_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.last) |-> in_stall_o)
    else $error("new transaction taken with the final byte of a string");
`endif

endmodule

### tb/sv/ehd_checker.sv
`timescale 1ns / 1ps

module ehd_checker import ehd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         err_cnt_o,
  output int         open_cnt_o,
  output int         in_cnt_o,
  output int         out_cnt_o,
  output int         decoded_cnt_o,
  output int         verbatim_cnt_o,
  output int         rescan_cnt_o
);

  localparam int RescanCap = EntityWindow + 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  dec_byte_t   decoded_q[$];
  dec_byte_t   step_q[$];
  logic [7:0]  rescan_q[$];
  logic [7:0]  win_buf [NumCells];
  int unsigned win_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $realtime, msg);
    err_cnt_o++;
  endtask

  function automatic void put_out(input logic [7:0] b);
    dec_byte_t item;
    item.data = b;
    item.last = 1'b0;
    if (step_q.size() < NumCells) begin
      step_q.insert(step_q.size(), item);
    end
  endfunction

  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Return UTF-8 length, 0 to keep the window verbatim, -1 if unknown.
  function automatic int decode_window(output logic [7:0] utf [4]);
    int unsigned len;
    logic [31:0] cp;
    logic [3:0]  dv;
    bit          big;
    len = win_cnt - 1;
    cp  = '0;
    big = 1'b0;
    for (int i = 0; i < 4; i++) utf[i] = '0;
    if (len == 3 && {win_buf[1], win_buf[2], win_buf[3]} == NameAmp) begin
      cp = 32'(CharAmp);
    end else if (len == 2 && {win_buf[1], win_buf[2]} == NameLt) begin
      cp = 32'(CharLt);
    end else if (len == 2 && {win_buf[1], win_buf[2]} == NameGt) begin
      cp = 32'(CharGt);
    end else if (len == 4 && {win_buf[1], win_buf[2], win_buf[3], win_buf[4]} == NameQuot) begin
      cp = 32'(CharQuot);
    end else if (len == 4 && {win_buf[1], win_buf[2], win_buf[3], win_buf[4]} == NameApos) begin
      cp = 32'(CharApos);
    end else if (len > 2 && win_buf[1] == CharHash &&
                 (win_buf[2] == CharLowX || win_buf[2] == CharUpX)) begin
      for (int j = 3; j <= int'(len); j++) begin
        if (!hex_digit(win_buf[j], dv)) return -1;
        if (!big) begin
          cp = cp * 16 + 32'(dv);
          if (cp > 32'(CpMax)) big = 1'b1;
        end
      end
    end else if (len > 1 && win_buf[1] == CharHash) begin
      for (int j = 2; j <= int'(len); j++) begin
        if (win_buf[j] < "0" || win_buf[j] > "9") return -1;
        if (!big) begin
          cp = cp * 10 + 32'(win_buf[j] - "0");
          if (cp > 32'(CpMax)) big = 1'b1;
        end
      end
    end else begin
      return -1;
    end
    if (big) return 0;
    if (cp < 32'h80) begin
      utf[0] = cp[7:0];
      return 1;
    end
    if (cp < 32'h800) begin
      utf[0] = {3'b110, cp[10:6]};
      utf[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 32'h10000) begin
      utf[0] = {4'b1110, cp[15:12]};
      utf[1] = {2'b10, cp[11:6]};
      utf[2] = {2'b10, cp[5:0]};
      return 3;
    end
    utf[0] = {5'b11110, cp[20:18]};
    utf[1] = {2'b10, cp[17:12]};
    utf[2] = {2'b10, cp[11:6]};
    utf[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  // Emit '&' and push the rest of the window back in front of the rescan queue.
  function automatic void abandon_window(input bit has_extra, input logic [7:0] extra);
    logic [7:0] tmp[$];
    put_out(CharAmp);
    rescan_cnt_o++;
    for (int i = 1; i < int'(win_cnt) && tmp.size() < RescanCap; i++) begin
      tmp.insert(tmp.size(), win_buf[i]);
    end
    if (has_extra && tmp.size() < RescanCap) tmp.insert(tmp.size(), extra);
    foreach (rescan_q[i]) begin
      if (tmp.size() < RescanCap) tmp.insert(tmp.size(), rescan_q[i]);
    end
    rescan_q = tmp;
    win_cnt  = 0;
  endfunction

  function automatic void scan_bytes();
    logic [7:0] b;
    logic [7:0] utf [4];
    int         n;
    while (rescan_q.size() > 0) begin
      b = rescan_q.pop_front();
      if (win_cnt == 0) begin
        if (b == CharAmp) begin
          win_buf[0] = b;
          win_cnt    = 1;
        end else begin
          put_out(b);
        end
      end else if (b == CharSemi) begin
        n = decode_window(utf);
        if (n < 0) begin
          abandon_window(1'b1, b);
        end else if (n == 0) begin
          for (int k = 0; k < int'(win_cnt); k++) put_out(win_buf[k]);
          put_out(CharSemi);
          win_cnt = 0;
          verbatim_cnt_o++;
        end else begin
          for (int k = 0; k < n; k++) put_out(utf[k]);
          win_cnt = 0;
          decoded_cnt_o++;
        end
      end else if (win_cnt >= EntityWindow) begin
        abandon_window(1'b1, b);
      end else begin
        win_buf[win_cnt] = b;
        win_cnt++;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    step_q.delete();
    rescan_q.delete();
    rescan_q.insert(rescan_q.size(), b);
    scan_bytes();
    if (last) begin
      while (win_cnt > 0) begin
        abandon_window(1'b0, 8'h00);
        scan_bytes();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    end
    foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
  endfunction

  initial begin
    err_cnt_o      = 0;
    open_cnt_o     = 0;
    in_cnt_o       = 0;
    out_cnt_o      = 0;
    decoded_cnt_o  = 0;
    verbatim_cnt_o = 0;
    rescan_cnt_o   = 0;
    win_cnt        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    dec_byte_t want;
    if (!rst_ni) begin
      decoded_q.delete();
      win_cnt    = 0;
      open_cnt_o = 0;
    end else begin
      // check outputs first: this edge's input cannot have produced them yet
      if (out_valid_i && !out_stall_i) begin
        out_cnt_o++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h last %b",
                                    out_byte_i, out_last_i));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_i, want.data));
          end
          if (out_last_i !== want.last) begin
            report_mismatch($sformatf("out_last %b, want %b (byte %02h)",
                                      out_last_i, want.last, want.data));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        in_cnt_o++;
        decode_byte(in_byte_i, in_last_i);
      end
      open_cnt_o = decoded_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ehd_pkg::*;

  localparam int RandomBytes = 170;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 40;
  localparam int MaxGap      = 13;

  typedef enum int {
    TOK_PLAIN,
    TOK_NAMED,
    TOK_DEC,
    TOK_HEX,
    TOK_BROKEN
  } token_e;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] text_q[$];
  string      entity_names [5] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};

  int err_cnt, open_cnt, in_cnt, out_cnt, decoded_cnt, verbatim_cnt, rescan_cnt;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  html_entity_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .out_last_o (out_last)
  );

  ehd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_byte_i     (in_byte),
    .in_last_i     (in_last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_i    (out_byte),
    .out_last_i    (out_last),
    .err_cnt_o     (err_cnt),
    .open_cnt_o    (open_cnt),
    .in_cnt_o      (in_cnt),
    .out_cnt_o     (out_cnt),
    .decoded_cnt_o (decoded_cnt),
    .verbatim_cnt_o(verbatim_cnt),
    .rescan_cnt_o  (rescan_cnt)
  );

  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void push_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  function automatic longint unsigned pick_code_point();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 'h7F);
      1:       return $urandom_range('h80, 'h7FF);
      2:       return $urandom_range('h800, 'hFFFF);
      3:       return $urandom_range('h10000, 'h10FFFF);
      4:       return $urandom_range('h110000, 'hFFFFFF);
      default: return {$urandom, $urandom} >> $urandom_range(0, 40);
    endcase
  endfunction

  function automatic void push_number(input longint unsigned v, input bit hex);
    string      digits;
    logic [7:0] c;
    int         zeros;
    zeros  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
    add_byte(CharAmp);
    add_byte(CharHash);
    if (hex) add_byte($urandom_range(0, 1) ? CharLowX : CharUpX);
    repeat (zeros) add_byte("0");
    foreach (digits[i]) begin
      c = digits[i];
      if (hex && c >= "a" && c <= "f" && $urandom_range(0, 1)) c = c - 8'h20;
      add_byte(c);
    end
    add_byte(CharSemi);
  endfunction

  function automatic void push_broken();
    int start;
    case ($urandom_range(0, 6))
      0: begin
        add_byte(CharAmp);
        repeat ($urandom_range(1, 14)) add_byte(8'($urandom_range("a", "z")));
      end
      1: begin
        case ($urandom_range(0, 6))
          0:       push_text("&;");
          1:       push_text("&#;");
          2:       push_text("&#x;");
          3:       push_text("&AMP;");
          4:       push_text("&#12a;");
          5:       push_text("&#xg1;");
          default: push_text("&ampx;");
        endcase
      end
      2: add_byte(CharAmp);
      3: add_byte(CharSemi);
      4: begin
        start = text_q.size();
        push_text(entity_names[$urandom_range(0, 4)]);
        text_q[$urandom_range(start, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      5: begin
        add_byte(CharAmp);
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
        add_byte(CharSemi);
      end
      default: push_text("&&#x41;");
    endcase
  endfunction

  function automatic void build_random_text();
    int     roll;
    token_e tok;
    repeat ($urandom_range(1, 5)) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      tok = TOK_PLAIN;
      else if (roll < 55) tok = TOK_NAMED;
      else if (roll < 70) tok = TOK_DEC;
      else if (roll < 85) tok = TOK_HEX;
      else                tok = TOK_BROKEN;
      case (tok)
        TOK_PLAIN: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        TOK_NAMED: push_text(entity_names[$urandom_range(0, 4)]);
        TOK_DEC:   push_number(pick_code_point(), 1'b0);
        TOK_HEX:   push_number(pick_code_point(), 1'b1);
        default:   push_broken();
      endcase
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic send_string(input string s);
    push_text(s);
    send_text();
  endtask

  // receiver: random stall per transaction, plus one long hold-off on request
  initial begin
    int stall_cycles;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall_cycles = HoldCycles;
        hold_req     = 1'b0;
      end else begin
        stall_cycles = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      end
      if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int rand_sent;
    rand_sent = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_string("&amp;&lt;&gt;&quot;&apos;");
    send_string("&#0;&#x10FFFF;&#X7ff;");
    send_string("&#1114112;&#xD800;");
    send_string("&;&#;&#x;");
    send_string("&abcdefghijklm");
    add_byte(8'h00);
    add_byte(8'hFF);
    send_text();
    send_string("&#65536;");
    send_string("x&");

    tx_quiet = 1'b1;
    hold_req = 1'b1;
    while (rand_sent < RandomBytes) begin
      build_random_text();
      rand_sent += text_q.size();
      send_text();
    end
    in_valid <= 1'b0;

    while (open_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input bytes and %0d checked output bytes.", in_cnt, out_cnt);
    $display("Entities: %0d decoded, %0d kept verbatim, %0d windows rescanned.",
             decoded_cnt, verbatim_cnt, rescan_cnt);
    if (err_cnt == 0 && open_cnt == 0) begin
      $display("PASS html_entity_decoder");
    end else begin
      $display("FAIL html_entity_decoder");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL html_entity_decoder");
    $finish;
  end

endmodule

### html_entity_decoder.f
rtl/core/ehd_pkg.sv
rtl/core/ehd_cell.sv
rtl/core/ehd_scan.sv
rtl/core/html_entity_decoder.sv
tb/sv/ehd_checker.sv
tb/sv/tb_top.sv
